// ===== src/ppts_pkg.sv =====
// Package for the perspective projection block: widths, constants, divider stage type.
// Used by perspective_project_to_screen and its checker; depends on nothing.
package ppts_pkg;

  localparam int unsigned DefScreenWidth  = 1280;
  localparam int unsigned DefScreenHeight = 720;
  localparam int unsigned NumRegs   = 8;
  localparam int unsigned IdxW      = 8;
  localparam int unsigned DimW      = 15;   // signed width holding up to 16383
  localparam int unsigned ClipW     = 50;
  localparam int unsigned QW        = 35;
  localparam int unsigned DivSteps  = 35;
  localparam logic signed [31:0] OffMark = 32'sd1000 * -32'sd65536;
  localparam logic [QW-1:0] NdcLimit = QW'(64'd1 << 34);

  typedef struct packed {
    logic             off;
    logic             neg_x;
    logic             neg_y;
    logic             sat_x;
    logic             sat_y;
    logic [ClipW-1:0] den;
    logic [ClipW-1:0] rem_x;
    logic [ClipW-1:0] rem_y;
    logic [QW-1:0]    nlo_x;
    logic [QW-1:0]    nlo_y;
    logic [QW-1:0]    quo_x;
    logic [QW-1:0]    quo_y;
  } div_t;

  // one restoring step of a numerator/denominator pair
  function automatic logic [ClipW+QW+QW-1:0] div_bit(logic [ClipW-1:0] rem,
      logic [QW-1:0] nlo, logic [QW-1:0] quo, logic [ClipW-1:0] den);
    logic [ClipW-1:0] t;
    logic             ge;
    t  = {rem[ClipW-2:0], nlo[QW-1]};
    ge = (t >= den);
    return {(ge ? t - den : t), {nlo[QW-2:0], 1'b0}, {quo[QW-2:0], ge}};
  endfunction

  function automatic div_t div_step(div_t a);
    div_t r;
    r = a;
    {r.rem_x, r.nlo_x, r.quo_x} = div_bit(a.rem_x, a.nlo_x, a.quo_x, a.den);
    {r.rem_y, r.nlo_y, r.quo_y} = div_bit(a.rem_y, a.nlo_y, a.quo_y, a.den);
    return r;
  endfunction

endpackage

// ===== src/perspective_project_to_screen.sv =====
// Perspective projection pipeline: matrix multiply, clip test, divide, viewport map.
// Depends on ppts_pkg.
//
// Takes one world point per cycle while not stalled and returns one screen point per
// point, in order. The pipeline is one stage of twelve 32x32 products, one of column
// sums, one of clip test and divider setup, 35 stages of a restoring divider that
// yields one quotient bit per stage for x and y together, one viewport multiply and
// one output register. Each stage holds its beat until the next frees up, so bubbles
// close up under stall. Write the matrix only while idle.
module perspective_project_to_screen #(
  parameter int unsigned SCREEN_WIDTH  = ppts_pkg::DefScreenWidth,
  parameter int unsigned SCREEN_HEIGHT = ppts_pkg::DefScreenHeight
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ppts_pkg::IdxW-1:0]  cfg_index_i,
  input  logic [63:0]                cfg_data_i,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic signed [31:0]         world_x_i,
  input  logic signed [31:0]         world_y_i,
  input  logic signed [31:0]         world_z_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output logic signed [31:0]         screen_x_o,
  output logic signed [31:0]         screen_y_o,
  output logic                       off_screen_o
);

  localparam int unsigned CW = ppts_pkg::ClipW;
  localparam int unsigned QW = ppts_pkg::QW;
  localparam int unsigned NS = ppts_pkg::DivSteps;
  localparam logic signed [ppts_pkg::DimW-1:0] ScrW = ppts_pkg::DimW'(SCREEN_WIDTH);
  localparam logic signed [ppts_pkg::DimW-1:0] ScrH = ppts_pkg::DimW'(SCREEN_HEIGHT);
  localparam int unsigned PW = 37 + ppts_pkg::DimW;

  logic [63:0] mat_q [ppts_pkg::NumRegs];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ppts_pkg::NumRegs; i++) mat_q[i] <= '0;
    end else if (cfg_valid_i && cfg_index_i < ppts_pkg::IdxW'(ppts_pkg::NumRegs)) begin
      mat_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  // handshake chain
  logic v1_q, v2_q, vm_q, vo_q;
  logic [NS:0] dv_q;
  logic rdy1, rdy2, rdy_m, rdy_o;
  logic [NS:0] rdy_d;

  always_comb begin
    rdy_o = !vo_q || !stall_i;
    rdy_m = !vm_q || rdy_o;
    rdy_d[NS] = !dv_q[NS] || rdy_m;
    for (int j = NS - 1; j >= 0; j--) rdy_d[j] = !dv_q[j] || rdy_d[j+1];
    rdy2 = !v2_q || rdy_d[0];
    rdy1 = !v1_q || rdy2;
  end
  assign stall_o = !rdy1;

  // stage 1: products, floored to Q16.16
  logic signed [47:0] prod_q [4][3];
  logic signed [31:0] tail_q [4];

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      for (int c = 0; c < 4; c++) begin
        prod_q[c][0] <= 48'((64'(world_x_i) * 64'(signed'(mat_q[2*c][31:0]))) >>> 16);
        prod_q[c][1] <= 48'((64'(world_y_i) * 64'(signed'(mat_q[2*c][63:32]))) >>> 16);
        prod_q[c][2] <= 48'((64'(world_z_i) * 64'(signed'(mat_q[2*c+1][31:0]))) >>> 16);
        tail_q[c]    <= signed'(mat_q[2*c+1][63:32]);
      end
    end
  end

  // stage 2: clip coordinates
  logic signed [CW-1:0] clip_q [4];

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      for (int c = 0; c < 4; c++) begin
        clip_q[c] <= CW'(prod_q[c][0]) + CW'(prod_q[c][1]) + CW'(prod_q[c][2])
                   + CW'(tail_q[c]);
      end
    end
  end

  // stage 3: clip test and divider setup
  ppts_pkg::div_t div_d0;
  ppts_pkg::div_t div_q [NS+1];

  always_comb begin
    logic [CW-1:0] nx, ny;
    nx = clip_q[0][CW-1] ? CW'(-clip_q[0]) : CW'(clip_q[0]);
    ny = clip_q[1][CW-1] ? CW'(-clip_q[1]) : CW'(clip_q[1]);
    div_d0.off   = (clip_q[3] <= 0) || (clip_q[2] < 0) || (clip_q[2] > clip_q[3]);
    div_d0.neg_x = clip_q[0][CW-1];
    div_d0.neg_y = clip_q[1][CW-1];
    div_d0.den   = CW'(clip_q[3]);
    div_d0.sat_x = (CW'(nx >> 19) >= CW'(clip_q[3]));
    div_d0.sat_y = (CW'(ny >> 19) >= CW'(clip_q[3]));
    div_d0.rem_x = CW'(nx >> 19);
    div_d0.rem_y = CW'(ny >> 19);
    div_d0.nlo_x = {nx[18:0], 16'b0};
    div_d0.nlo_y = {ny[18:0], 16'b0};
    div_d0.quo_x = '0;
    div_d0.quo_y = '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy_d[0]) div_q[0] <= div_d0;
  end

  for (genvar j = 1; j <= NS; j++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (rdy_d[j]) div_q[j] <= ppts_pkg::div_step(div_q[j-1]);
    end
  end

  // viewport multiply
  logic [QW-1:0] mag_x, mag_y;
  logic signed [QW:0] ndc_x, ndc_y;
  logic signed [PW-1:0] px_q, py_q;
  logic off_m_q;

  always_comb begin
    mag_x = (div_q[NS].sat_x || div_q[NS].quo_x > ppts_pkg::NdcLimit)
          ? ppts_pkg::NdcLimit : div_q[NS].quo_x;
    mag_y = (div_q[NS].sat_y || div_q[NS].quo_y > ppts_pkg::NdcLimit)
          ? ppts_pkg::NdcLimit : div_q[NS].quo_y;
    ndc_x = div_q[NS].neg_x ? -signed'({1'b0, mag_x}) : signed'({1'b0, mag_x});
    ndc_y = div_q[NS].neg_y ? -signed'({1'b0, mag_y}) : signed'({1'b0, mag_y});
  end

  always_ff @(posedge clk_i) begin
    if (rdy_m) begin
      px_q    <= PW'(37'(ndc_x) + 37'sd65536) * PW'(ScrW);
      py_q    <= PW'(37'sd65536 - 37'(ndc_y)) * PW'(ScrH);
      off_m_q <= div_q[NS].off;
    end
  end

  // halve toward zero, saturate, select marker
  function automatic logic signed [31:0] half_sat(logic signed [PW-1:0] p);
    logic signed [PW-1:0] h;
    h = (p + signed'(PW'(p[PW-1]))) >>> 1;
    if (h > PW'(32'sh7fffffff)) return 32'sh7fffffff;
    if (h < -PW'(64'sh80000000)) return 32'sh80000000;
    return h[31:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (rdy_o) begin
      screen_x_o   <= off_m_q ? ppts_pkg::OffMark : half_sat(px_q);
      screen_y_o   <= off_m_q ? ppts_pkg::OffMark : half_sat(py_q);
      off_screen_o <= off_m_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      dv_q <= '0;
      vm_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy_d[0]) dv_q[0] <= v2_q;
      for (int j = 1; j <= NS; j++) if (rdy_d[j]) dv_q[j] <= dv_q[j-1];
      if (rdy_m) vm_q <= dv_q[NS];
      if (rdy_o) vo_q <= vm_q;
    end
  end

  assign valid_o = vo_q;

endmodule

// ===== src/ppts_checker.sv =====
// Port-level checks for perspective_project_to_screen, bound to the top level.
// Depends on ppts_pkg.
module ppts_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               valid_o,
  input logic               stall_i,
  input logic               stall_o,
  input logic signed [31:0] screen_x_o,
  input logic signed [31:0] screen_y_o,
  input logic               off_screen_o
);

  // off-screen beats carry the marker
  a_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && off_screen_o |->
      screen_x_o == ppts_pkg::OffMark && screen_y_o == ppts_pkg::OffMark)
    else $error("off-screen beat without marker");

  // with no result waiting the input is never stalled
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !stall_o)
    else $error("input stalled with empty output");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(screen_x_o) && $stable(screen_y_o))
    else $error("stalled result changed");

endmodule

bind perspective_project_to_screen ppts_checker u_ppts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid_o      (valid_o),
  .stall_i      (stall_i),
  .stall_o      (stall_o),
  .screen_x_o   (screen_x_o),
  .screen_y_o   (screen_y_o),
  .off_screen_o (off_screen_o)
);
